// File: rtl/bracket_command_stream_validator_defines.svh
// Assertion macros shared by the validator RTL.
// Each macro takes a label, the clock, the reset and the terms of the property.
`ifndef BRACKET_COMMAND_STREAM_VALIDATOR_DEFINES_SVH
`define BRACKET_COMMAND_STREAM_VALIDATOR_DEFINES_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define BCSV_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcsv assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define BCSV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcsv assertion failed");
`else
`define BCSV_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define BCSV_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/bcsv_pkg.sv
package bcsv_pkg;

  localparam int MAX_DEPTH_DEFAULT = 255;

  // Characters the parser recognizes.
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_LT    = "<";
  localparam logic [7:0] CH_GT    = ">";
  localparam logic [7:0] CH_OPEN  = "[";
  localparam logic [7:0] CH_CLOSE = "]";
  localparam logic [7:0] CH_S     = "s";
  localparam logic [7:0] CH_R     = "r";
  localparam logic [7:0] CH_Q     = "q";
  localparam logic [7:0] CH_F     = "f";
  localparam logic [7:0] CH_A     = "a";
  localparam logic [7:0] CH_C     = "c";
  localparam logic [7:0] CH_T     = "t";
  localparam logic [7:0] CH_M     = "m";
  localparam logic [7:0] CH_D     = "d";
  localparam logic [7:0] CH_E     = "e";
  localparam logic [7:0] CH_V     = "v";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] DIGIT_SPAN = 8'd9;

  localparam logic [7:0] OPEN_COUNT_TOP = 8'hFF;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_S    = 4'd1,
    PH_F    = 4'd2,
    PH_FA   = 4'd3,
    PH_FAC  = 4'd4,
    PH_MDE  = 4'd5,
    PH_TWO  = 4'd6,
    PH_ONE  = 4'd7
  } phase_t;

  typedef enum logic [2:0] {
    R_OK       = 3'd0,
    R_BADCHAR  = 3'd1,
    R_BADEXT   = 3'd2,
    R_STRAY    = 3'd3,
    R_UNCLOSED = 3'd4,
    R_DEPTH    = 3'd5
  } reason_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic       valid_res;
    logic [2:0] reason;
  } out_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] open_count;
    reason_t    error_code;
    logic       text_ended;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    phase:      PH_IDLE,
    open_count: 8'd0,
    error_code: R_OK,
    text_ended: 1'b0
  };

endpackage

// File: rtl/bracket_command_stream_validator.sv
// A last beat passes the input register, and its verdict is then registered into res.
// Throughput: one text byte per cycle while verdicts are taken from res.
// Beats not marked last give no result; res is a one-entry output register.
// Reset (rst, synchronous, active high) empties both registers and returns the
// scanner to idle with no open brackets, no error and the text not ended.
`include "bracket_command_stream_validator_defines.svh"

module bracket_command_stream_validator #(
  parameter int MAX_DEPTH = bcsv_pkg::MAX_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  bcsv_pkg::in_t  cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output bcsv_pkg::out_t res
);
  import bcsv_pkg::*;

  // Input register. A beat waits here until it fires; it then updates the scanner
  // state in a single step.
  logic        hold_valid;
  in_t         hold;

  // Scanner state: the command in progress, the bracket depth, the first
  // error seen and whether a zero byte has ended the text.
  scan_state_t scan;
  scan_state_t scan_next;
  out_t        verdict;

  logic        res_free;
  logic        hold_fire;
  logic        hold_emits;

  // The output register can take a new verdict when it is empty or being read.
  assign res_free   = !res_valid || res_ready;

  // A beat that is not marked last never needs the output register, so it
  // moves on at once. A last beat waits only while an older verdict is stuck.
  assign hold_fire  = hold_valid && (!hold.last || res_free);
  assign hold_emits = hold_fire && hold.last;

  // The input register refills in the same cycle it drains, so bytes stream
  // one per cycle as long as verdicts are taken.
  assign cmd_ready  = !hold_valid || hold_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd_ready) begin
      hold_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      hold <= cmd;
    end
  end

  bcsv_step #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_step (
    .cur    (scan),
    .beat   (hold),
    .nxt    (scan_next),
    .verdict(verdict)
  );

  // The step logic already folds in the return to the idle state after a
  // last beat, so the state register simply follows it.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= SCAN_RESET;
    end else if (hold_fire) begin
      scan <= scan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (hold_emits) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_emits) begin
      res <= verdict;
    end
  end

  // The ok flag and the reason code must agree on every verdict shown.
  `BCSV_ASSERT_SAME(a_flag_matches_reason, clk, rst, res_valid, res.valid_res == (res.reason == R_OK))
  // After a last beat the scanner starts the next text from idle.
  `BCSV_ASSERT_NEXT(a_reset_after_last, clk, rst, hold_emits, scan == SCAN_RESET)
  // The bracket depth never passes the limit.
  `BCSV_ASSERT_SAME(a_depth_bound, clk, rst, 1'b1, 16'(scan.open_count) <= 16'(MAX_DEPTH))
  // A verdict is never dropped: a last beat fires only into a free output register.
  `BCSV_ASSERT_SAME(a_no_overwrite, clk, rst, hold_emits, !res_valid || res_ready)

endmodule

// File: rtl/bcsv_step.sv
module bcsv_step #(
  parameter int MAX_DEPTH = bcsv_pkg::MAX_DEPTH_DEFAULT
) (
  input  bcsv_pkg::scan_state_t cur,
  input  bcsv_pkg::in_t         beat,
  output bcsv_pkg::scan_state_t nxt,
  output bcsv_pkg::out_t        verdict
);
  import bcsv_pkg::*;

  localparam logic [15:0] DEPTH_LIMIT = 16'(MAX_DEPTH);

  logic    is_digit;
  logic    at_top;
  logic    ext_ok;
  phase_t  ext_next;
  reason_t why;
  scan_state_t st;

  assign is_digit = (beat.text_byte >= CH_ZERO) && (beat.text_byte <= CH_ZERO + DIGIT_SPAN);
  assign at_top   = ({8'd0, cur.open_count} >= DEPTH_LIMIT) || (cur.open_count == OPEN_COUNT_TOP);

  // Check of a byte inside an extended command.
  always_comb begin
    ext_ok   = 1'b0;
    ext_next = PH_IDLE;
    case (cur.phase)
      PH_S: begin
        ext_ok = (beat.text_byte == CH_R) || (beat.text_byte == CH_Q);
      end
      PH_F: begin
        ext_ok   = (beat.text_byte == CH_A);
        ext_next = PH_FA;
      end
      PH_FA: begin
        ext_ok   = (beat.text_byte == CH_C);
        ext_next = PH_FAC;
      end
      PH_FAC: begin
        ext_ok = (beat.text_byte == CH_T);
      end
      PH_MDE: begin
        ext_ok   = (beat.text_byte == CH_V) || is_digit;
        ext_next = PH_TWO;
      end
      PH_TWO: begin
        ext_ok   = is_digit;
        ext_next = PH_ONE;
      end
      PH_ONE: begin
        ext_ok = is_digit;
      end
      default: begin
        ext_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    st = cur;
    if ((cur.error_code == R_OK) && !cur.text_ended) begin
      if (cur.phase != PH_IDLE) begin
        if (ext_ok) begin
          st.phase = ext_next;
        end else begin
          st.error_code = R_BADEXT;
          st.phase      = PH_IDLE;
        end
      end else if (beat.text_byte == CH_NUL) begin
        st.text_ended = 1'b1;
      end else begin
        case (beat.text_byte)
          CH_DOT, CH_COMMA, CH_PLUS, CH_MINUS, CH_LT, CH_GT: begin
            st.phase = PH_IDLE;
          end
          CH_OPEN: begin
            if (at_top) begin
              st.error_code = R_DEPTH;
            end else begin
              st.open_count = cur.open_count + 8'd1;
            end
          end
          CH_CLOSE: begin
            if (cur.open_count == 8'd0) begin
              st.error_code = R_STRAY;
            end else begin
              st.open_count = cur.open_count - 8'd1;
            end
          end
          CH_S: begin
            st.phase = PH_S;
          end
          CH_F: begin
            st.phase = PH_F;
          end
          CH_M, CH_D, CH_E: begin
            st.phase = PH_MDE;
          end
          default: begin
            st.error_code = R_BADCHAR;
          end
        endcase
      end
    end
  end

  // The first recorded error wins, then a cut-off command, then open brackets.
  always_comb begin
    if (st.error_code != R_OK) begin
      why = st.error_code;
    end else if (st.phase != PH_IDLE) begin
      why = R_BADEXT;
    end else if (st.open_count != 8'd0) begin
      why = R_UNCLOSED;
    end else begin
      why = R_OK;
    end
  end

  assign verdict.valid_res = (why == R_OK);
  assign verdict.reason    = why;
  assign nxt               = beat.last ? SCAN_RESET : st;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bcsv_pkg::*;

  // The block is built with its default nesting limit, which equals the top of
  // the 8-bit open-bracket counter.
  localparam int DEPTH_LIMIT    = MAX_DEPTH_DEFAULT;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_BEATS   = 300;
  // A verdict shows up once the last beat has passed the input and output registers.
  // The drain cycles give any stray extra result time to appear before the run ends.
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam bit TYPED          = 1'b1;
  localparam bit PREDICTED      = 1'b0;

  typedef logic [7:0] text_q_t[$];

  // One row of the directed table. The text is a run of open brackets, then
  // the head, then an optional zero byte, then the tail. The last byte of the
  // text carries the last flag. Where typed is set, the verdict is written in
  // the row. Otherwise the predictor supplies it.
  typedef struct {
    int      opens;
    string   head;
    bit      nul;
    string   tail;
    bit      typed;
    reason_t verdict;
  } text_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  in_t  cmd       = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  out_t res;

  bracket_command_stream_validator #(
    .MAX_DEPTH(DEPTH_LIMIT)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always #10 clk = ~clk;

  // Predictor state. It mirrors the scanner and goes back to reset after
  // every beat that is marked last.
  phase_t     pv_phase = PH_IDLE;
  logic [7:0] pv_depth = 8'd0;
  reason_t    pv_error = R_OK;
  logic       pv_ended = 1'b0;

  out_t      verdicts_due[$];
  text_row_t directed_rows[$];

  logic [7:0] single_cmds[6] = '{CH_DOT, CH_COMMA, CH_PLUS, CH_MINUS, CH_LT, CH_GT};
  logic [7:0] lead_cmds[3]   = '{CH_M, CH_D, CH_E};

  int errors         = 0;
  int beats_sent     = 0;
  int texts_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int verdict_tally[6];

  task automatic flag_mismatch(input string what);
    $display("%0d ns: mismatch: %s", $time, what);
    errors++;
  endtask

  // Runs one byte through the predicted scanner. It returns 1 and fills
  // verdict when the beat closes a text.
  function automatic bit scan_byte(input in_t beat, output out_t verdict);
    logic [7:0] b;
    logic       digit;
    bit         fits;
    phase_t     after;
    reason_t    r;
    b       = beat.text_byte;
    digit   = (b >= CH_ZERO) && (b <= CH_ZERO + DIGIT_SPAN);
    verdict = '0;
    if (pv_error == R_OK && !pv_ended) begin
      if (pv_phase != PH_IDLE) begin
        // Inside an extended command, any byte that does not fit is fatal,
        // a zero byte included.
        fits  = 1'b0;
        after = PH_IDLE;
        case (pv_phase)
          PH_S:   fits = (b == CH_R) || (b == CH_Q);
          PH_F: begin
            fits  = (b == CH_A);
            after = PH_FA;
          end
          PH_FA: begin
            fits  = (b == CH_C);
            after = PH_FAC;
          end
          PH_FAC: fits = (b == CH_T);
          PH_MDE: begin
            fits  = (b == CH_V) || digit;
            after = PH_TWO;
          end
          PH_TWO: begin
            fits  = digit;
            after = PH_ONE;
          end
          PH_ONE: fits = digit;
          default: fits = 1'b0;
        endcase
        if (fits) begin
          pv_phase = after;
        end else begin
          pv_error = R_BADEXT;
          pv_phase = PH_IDLE;
        end
      end else begin
        case (b)
          CH_NUL: pv_ended = 1'b1;
          CH_DOT, CH_COMMA, CH_PLUS, CH_MINUS, CH_LT, CH_GT: ;
          CH_OPEN: begin
            if (int'(pv_depth) >= DEPTH_LIMIT || pv_depth == OPEN_COUNT_TOP) begin
              pv_error = R_DEPTH;
            end else begin
              pv_depth++;
            end
          end
          CH_CLOSE: begin
            if (pv_depth == 8'd0) begin
              pv_error = R_STRAY;
            end else begin
              pv_depth--;
            end
          end
          CH_S: pv_phase = PH_S;
          CH_F: pv_phase = PH_F;
          CH_M, CH_D, CH_E: pv_phase = PH_MDE;
          default: pv_error = R_BADCHAR;
        endcase
      end
    end
    if (!beat.last) return 1'b0;
    // A recorded error wins, then a command cut off, then open brackets left.
    if (pv_error != R_OK) r = pv_error;
    else if (pv_phase != PH_IDLE) r = R_BADEXT;
    else if (pv_depth != 8'd0) r = R_UNCLOSED;
    else r = R_OK;
    verdict.valid_res = (r == R_OK);
    verdict.reason    = r;
    pv_phase = PH_IDLE;
    pv_depth = 8'd0;
    pv_error = R_OK;
    pv_ended = 1'b0;
    return 1'b1;
  endfunction

  // Offers one beat, holding it until the block takes it. Sender idle cycles
  // come before the beat, so they fall between any two bytes of a text.
  task automatic send_beat(input logic [7:0] b, input logic lst, input bit typed,
                           input reason_t verdict);
    in_t  beat;
    out_t predicted;
    beat.text_byte = b;
    beat.last      = lst;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= beat;
    do @(posedge clk); while (!cmd_ready);
    beats_sent++;
    if (scan_byte(beat, predicted)) begin
      if (typed) begin
        predicted.valid_res = (verdict == R_OK);
        predicted.reason    = verdict;
      end
      verdicts_due.push_back(predicted);
      verdict_tally[int'(predicted.reason)]++;
    end
  endtask

  task automatic send_text(input text_q_t txt, input bit typed, input reason_t verdict);
    for (int i = 0; i < txt.size(); i++) begin
      send_beat(txt[i], i == txt.size() - 1, typed, verdict);
    end
    texts_sent++;
  endtask

  function automatic void add_row(input int opens, input string head, input bit nul,
                                  input string tail, input bit typed,
                                  input reason_t verdict);
    text_row_t row;
    row.opens   = opens;
    row.head    = head;
    row.nul     = nul;
    row.tail    = tail;
    row.typed   = typed;
    row.verdict = verdict;
    directed_rows.push_back(row);
  endfunction

  // Random texts. Most are well formed with random content, because only
  // those get deep into the extended-command and bracket states. Some are
  // then broken in one place, and a few are pure noise over all byte values.
  function automatic void make_text(output text_q_t txt);
    int kind;
    int tokens;
    int open_now;
    int pick;
    int pos;
    txt      = {};
    kind     = $urandom_range(99);
    open_now = 0;
    if (kind < 12) begin
      repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(255)));
      return;
    end
    tokens = $urandom_range(1, 12);
    repeat (tokens) begin
      pick = $urandom_range(9);
      if (pick < 3) begin
        txt.push_back(single_cmds[$urandom_range(5)]);
      end else if (pick < 5) begin
        if (open_now > 0 && $urandom_range(1) == 1) begin
          txt.push_back(CH_CLOSE);
          open_now--;
        end else begin
          txt.push_back(CH_OPEN);
          open_now++;
        end
      end else if (pick == 5) begin
        txt.push_back(CH_S);
        txt.push_back($urandom_range(1) ? CH_R : CH_Q);
      end else if (pick == 6) begin
        txt.push_back(CH_F);
        txt.push_back(CH_A);
        txt.push_back(CH_C);
        txt.push_back(CH_T);
      end else begin
        txt.push_back(lead_cmds[$urandom_range(2)]);
        if ($urandom_range(2) == 0) txt.push_back(CH_V);
        else txt.push_back(CH_ZERO + 8'($urandom_range(9)));
        txt.push_back(CH_ZERO + 8'($urandom_range(9)));
        txt.push_back(CH_ZERO + 8'($urandom_range(9)));
      end
    end
    // Most texts close what they opened; the rest end with brackets open.
    if ($urandom_range(3) != 0) repeat (open_now) txt.push_back(CH_CLOSE);
    if (kind < 40) begin
      pos = $urandom_range(txt.size() - 1);
      case ($urandom_range(3))
        0: txt[pos] = 8'($urandom_range(255));
        1: begin
          // Cutting the text short often leaves a command unfinished.
          pos = $urandom_range(1, txt.size());
          while (txt.size() > pos) void'(txt.pop_back());
        end
        2: begin
          // An early end of text, with junk after it that must be ignored.
          txt.insert(pos, CH_NUL);
          repeat ($urandom_range(0, 4)) txt.push_back(8'($urandom_range(255)));
        end
        default: txt.push_front(CH_CLOSE);
      endcase
    end
  endfunction

  // Results are sampled at the rising edge, before the block updates them.
  always @(posedge clk) begin
    out_t want;
    if (!rst && res_valid && res_ready) begin
      if (verdicts_due.size() == 0) begin
        flag_mismatch($sformatf("verdict %b/%0d with none expected", res.valid_res,
                                res.reason));
      end else begin
        want = verdicts_due.pop_front();
        if (res.valid_res !== want.valid_res) begin
          flag_mismatch($sformatf("valid_res %b, expected %b", res.valid_res,
                                  want.valid_res));
        end
        if (res.reason !== want.reason) begin
          flag_mismatch($sformatf("reason %0d, expected %0d", res.reason, want.reason));
        end
      end
    end
  end

  // The receiver stalls at random according to the current idling phase.
  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // The watchdog ends the run when no beat moves on either channel for too
  // long after reset.
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d verdicts outstanding",
               WATCHDOG_LIMIT, verdicts_due.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    text_q_t txt;
    int      directed_beats;

    // Directed texts. Each row runs after the previous verdict has reset the
    // scanner, so a row that follows an error also checks the return to reset.
    //       opens head              nul   tail      check      verdict
    add_row(0,   ".,+-<>",         1'b0, "",       TYPED,     R_OK);
    add_row(0,   "[[+]-]",         1'b0, "",       TYPED,     R_OK);
    add_row(0,   "]",              1'b0, "",       TYPED,     R_STRAY);
    add_row(0,   "[",              1'b0, "",       TYPED,     R_UNCLOSED);
    add_row(0,   "sqsr",           1'b0, "",       TYPED,     R_OK);
    add_row(0,   "fact",           1'b0, "",       TYPED,     R_OK);
    add_row(0,   "m000d999e509",   1'b0, "",       TYPED,     R_OK);
    add_row(0,   "mv09dv90ev55",   1'b0, "",       TYPED,     R_OK);
    add_row(0,   "x",              1'b0, "",       TYPED,     R_BADCHAR);
    add_row(0,   "\377",           1'b0, "",       TYPED,     R_BADCHAR);
    add_row(0,   "sx",             1'b0, "",       TYPED,     R_BADEXT);
    add_row(0,   "fac",            1'b0, "",       TYPED,     R_BADEXT);
    add_row(0,   "m12",            1'b0, "",       TYPED,     R_BADEXT);
    add_row(0,   "s",              1'b1, "",       TYPED,     R_BADEXT);
    add_row(0,   "[]",             1'b1, "]]x\377", TYPED,    R_OK);
    add_row(0,   "",               1'b1, "",       TYPED,     R_OK);
    add_row(0,   "]x",             1'b0, "",       TYPED,     R_STRAY);
    add_row(0,   "[x]",            1'b0, "",       TYPED,     R_BADCHAR);
    add_row(255, "[",              1'b0, "",       TYPED,     R_DEPTH);
    add_row(0,   "]",              1'b0, "",       TYPED,     R_STRAY);
    add_row(3,   "]",              1'b0, "",       TYPED,     R_UNCLOSED);
    add_row(0,   "m/5d:9ev1a",     1'b0, "",       PREDICTED, R_OK);
    add_row(0,   "fbsq[e9",        1'b0, "",       PREDICTED, R_OK);
    add_row(0,   "[d12]",          1'b1, "",       PREDICTED, R_OK);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[n]) begin
      txt = {};
      repeat (directed_rows[n].opens) txt.push_back(CH_OPEN);
      for (int i = 0; i < directed_rows[n].head.len(); i++) begin
        txt.push_back(directed_rows[n].head[i]);
      end
      if (directed_rows[n].nul) txt.push_back(CH_NUL);
      for (int i = 0; i < directed_rows[n].tail.len(); i++) begin
        txt.push_back(directed_rows[n].tail[i]);
      end
      send_text(txt, directed_rows[n].typed, directed_rows[n].verdict);
    end
    directed_beats = beats_sent;

    // Random texts in four idling phases: none, sender idle, receiver
    // stalling, and a light mix of both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct  = 11;
          recv_stall_pct = 11;
        end
      endcase
      while (beats_sent - directed_beats < (ph + 1) * RANDOM_BEATS / 4) begin
        make_text(txt);
        send_text(txt, PREDICTED, R_OK);
      end
    end
    cmd_valid <= 1'b0;

    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d texts over %0d beats, %0d of them random", texts_sent,
             beats_sent, beats_sent - directed_beats);
    $display("verdicts ok/char/ext/stray/unclosed/depth: %0d %0d %0d %0d %0d %0d, %s %0d",
             verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
             verdict_tally[4], verdict_tally[5], "mismatches", errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
